// ----- hw/rtl/mask_normalized_blend_assert.svh -----
// Assertion macros shared by the mask blend checker.
`ifndef MASK_NORMALIZED_BLEND_ASSERT_SVH
`define MASK_NORMALIZED_BLEND_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MNB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MNB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mnb_pkg.sv -----
// Types and constants of the mask normalized blend.
`timescale 1ns / 1ps

package mnb_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_BITS = WEIGHT_FRAC + 1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = WEIGHT_FRAC;
    // two front stages, divider, weight, multiply, sum, output
    localparam int PIPE_STAGES = DIV_STEPS + 6;

    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_BLEND = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_DIV
    } weight_kind_t;

    typedef struct packed {
        weight_kind_t kind;
        logic         neg;
    } mnb_ctrl_t;

endpackage

// ----- hw/rtl/mnb_front.sv -----
// Mask min/max tracking and the two front stages: offsets, span, weight class.
`timescale 1ns / 1ps

module mnb_front
    import mnb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int DEN_BITS    = SAMPLE_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic                          first,
    input  logic signed [SAMPLE_BITS-1:0] mask_sample,
    input  logic signed [SAMPLE_BITS-1:0] before_sample,
    input  logic signed [SAMPLE_BITS-1:0] after_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic        [DEN_BITS-1:0]    out_rem,
    output logic        [DEN_BITS-1:0]    out_den,
    output mnb_ctrl_t                     out_ctrl,
    output logic        [SAMPLE_BITS:0]   out_mag,
    output logic signed [SAMPLE_BITS-1:0] out_before
);

    localparam logic [DEN_BITS-1:0] SPAN_ONE = DEN_BITS'(1) << FRAC_BITS;

    logic signed [SAMPLE_BITS-1:0] mask_low_reg, mask_low_next;
    logic signed [SAMPLE_BITS-1:0] mask_high_reg, mask_high_next;

    logic                          a_valid_reg, a_valid_next;
    logic signed [SAMPLE_BITS:0]   a_num_reg, a_num_next;
    logic        [SAMPLE_BITS-1:0] a_span_reg, a_span_next;
    logic signed [SAMPLE_BITS:0]   a_diff_reg, a_diff_next;
    logic signed [SAMPLE_BITS-1:0] a_before_reg, a_before_next;

    logic                          b_valid_reg, b_valid_next;
    logic        [DEN_BITS-1:0]    b_rem_reg, b_rem_next;
    logic        [DEN_BITS-1:0]    b_den_reg, b_den_next;
    mnb_ctrl_t                     b_ctrl_reg, b_ctrl_next;
    logic        [SAMPLE_BITS:0]   b_mag_reg, b_mag_next;
    logic signed [SAMPLE_BITS-1:0] b_before_reg, b_before_next;

    logic                          a_ready;
    logic                          b_ready;
    logic                          take;
    logic        [SAMPLE_BITS:0]   span_full;
    logic        [DEN_BITS-1:0]    den;
    logic        [DEN_BITS-1:0]    num_u;
    logic                          num_pos;
    logic signed [SAMPLE_BITS:0]   diff_neg;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign take     = in_valid && a_ready;

    // running min/max and the first stage
    always_comb
    begin
        mask_low_next  = mask_low_reg;
        mask_high_next = mask_high_reg;
        if (take && op == OP_SCAN)
        begin
            if (first)
            begin
                mask_low_next  = mask_sample;
                mask_high_next = mask_sample;
            end
            else
            begin
                if (mask_sample < mask_low_reg)
                    mask_low_next = mask_sample;
                if (mask_sample > mask_high_reg)
                    mask_high_next = mask_sample;
            end
        end

        span_full     = {mask_high_reg[SAMPLE_BITS-1], mask_high_reg}
                      - {mask_low_reg[SAMPLE_BITS-1], mask_low_reg};
        a_valid_next  = a_ready ? (in_valid && op == OP_BLEND) : a_valid_reg;
        a_num_next    = a_num_reg;
        a_span_next   = a_span_reg;
        a_diff_next   = a_diff_reg;
        a_before_next = a_before_reg;
        if (take)
        begin
            a_num_next    = {mask_sample[SAMPLE_BITS-1], mask_sample}
                          - {mask_low_reg[SAMPLE_BITS-1], mask_low_reg};
            a_span_next   = span_full[SAMPLE_BITS-1:0];
            a_diff_next   = {after_sample[SAMPLE_BITS-1], after_sample}
                          - {before_sample[SAMPLE_BITS-1], before_sample};
            a_before_next = before_sample;
        end
    end

    // second stage: pick the divisor, sort out the trivial weights, split the difference
    always_comb
    begin
        den      = (a_span_reg == '0) ? SPAN_ONE : DEN_BITS'(a_span_reg);
        num_pos  = !a_num_reg[SAMPLE_BITS] && (a_num_reg != '0);
        num_u    = DEN_BITS'(a_num_reg[SAMPLE_BITS-1:0]);
        diff_neg = -a_diff_reg;

        b_valid_next  = b_ready ? a_valid_reg : b_valid_reg;
        b_rem_next    = b_rem_reg;
        b_den_next    = b_den_reg;
        b_ctrl_next   = b_ctrl_reg;
        b_mag_next    = b_mag_reg;
        b_before_next = b_before_reg;
        if (a_valid_reg && b_ready)
        begin
            b_den_next = den;
            if (!num_pos)
                b_ctrl_next.kind = KIND_ZERO;
            else if (num_u >= den)
                b_ctrl_next.kind = KIND_ONE;
            else
                b_ctrl_next.kind = KIND_DIV;
            b_rem_next       = (num_pos && num_u < den) ? num_u : '0;
            b_ctrl_next.neg  = a_diff_reg[SAMPLE_BITS];
            b_mag_next       = a_diff_reg[SAMPLE_BITS] ? diff_neg : a_diff_reg;
            b_before_next    = a_before_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            mask_low_reg  <= mask_low_next;
            mask_high_reg <= mask_high_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_num_reg    <= a_num_next;
        a_span_reg   <= a_span_next;
        a_diff_reg   <= a_diff_next;
        a_before_reg <= a_before_next;
        b_rem_reg    <= b_rem_next;
        b_den_reg    <= b_den_next;
        b_ctrl_reg   <= b_ctrl_next;
        b_mag_reg    <= b_mag_next;
        b_before_reg <= b_before_next;
    end

    assign out_valid  = b_valid_reg;
    assign out_rem    = b_rem_reg;
    assign out_den    = b_den_reg;
    assign out_ctrl   = b_ctrl_reg;
    assign out_mag    = b_mag_reg;
    assign out_before = b_before_reg;

endmodule

// ----- hw/rtl/mnb_div_step.sv -----
// One restoring division step: one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module mnb_div_step
    import mnb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DEN_BITS    = SAMPLE_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic        [DEN_BITS-1:0]    in_rem,
    input  logic        [DEN_BITS-1:0]    in_den,
    input  logic        [WEIGHT_FRAC-1:0] in_quo,
    input  mnb_ctrl_t                     in_ctrl,
    input  logic        [SAMPLE_BITS:0]   in_mag,
    input  logic signed [SAMPLE_BITS-1:0] in_before,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic        [DEN_BITS-1:0]    out_rem,
    output logic        [DEN_BITS-1:0]    out_den,
    output logic        [WEIGHT_FRAC-1:0] out_quo,
    output mnb_ctrl_t                     out_ctrl,
    output logic        [SAMPLE_BITS:0]   out_mag,
    output logic signed [SAMPLE_BITS-1:0] out_before
);

    logic                          valid_reg, valid_next;
    logic        [DEN_BITS-1:0]    rem_reg, rem_next;
    logic        [DEN_BITS-1:0]    den_reg, den_next;
    logic        [WEIGHT_FRAC-1:0] quo_reg, quo_next;
    mnb_ctrl_t                     ctrl_reg, ctrl_next;
    logic        [SAMPLE_BITS:0]   mag_reg, mag_next;
    logic signed [SAMPLE_BITS-1:0] before_reg, before_next;

    logic        [DEN_BITS:0]      shifted;
    logic        [DEN_BITS:0]      trial;
    logic                          fits;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // remainder stays below the divisor, so the shifted value is below twice it
        shifted = {in_rem, 1'b0};
        trial   = shifted - {1'b0, in_den};
        fits    = shifted >= {1'b0, in_den};

        valid_next  = in_ready ? in_valid : valid_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        ctrl_next   = ctrl_reg;
        mag_next    = mag_reg;
        before_next = before_reg;
        if (in_valid && in_ready)
        begin
            rem_next    = fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            den_next    = in_den;
            quo_next    = {in_quo[WEIGHT_FRAC-2:0], fits};
            ctrl_next   = in_ctrl;
            mag_next    = in_mag;
            before_next = in_before;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        ctrl_reg   <= ctrl_next;
        mag_reg    <= mag_next;
        before_reg <= before_next;
    end

    assign out_valid  = valid_reg;
    assign out_rem    = rem_reg;
    assign out_den    = den_reg;
    assign out_quo    = quo_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_mag    = mag_reg;
    assign out_before = before_reg;

endmodule

// ----- hw/rtl/mnb_scale.sv -----
// Back end: weight select and invert, split multiply, sum, final add and output register.
`timescale 1ns / 1ps

module mnb_scale
    import mnb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          invert_mask,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic        [WEIGHT_FRAC-1:0] in_quo,
    input  mnb_ctrl_t                     in_ctrl,
    input  logic        [SAMPLE_BITS:0]   in_mag,
    input  logic signed [SAMPLE_BITS-1:0] in_before,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] blended_sample,
    output logic        [WEIGHT_BITS-1:0] mix_weight
);

    localparam int MAG_BITS  = SAMPLE_BITS + 1;
    localparam int HI_BITS   = MAG_BITS - WEIGHT_FRAC;
    localparam int PHI_BITS  = HI_BITS + WEIGHT_BITS;
    localparam int PLO_BITS  = WEIGHT_FRAC + WEIGHT_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;

    // weight stage
    logic                          w_valid_reg, w_valid_next;
    logic        [WEIGHT_BITS-1:0] w_weight_reg, w_weight_next;
    logic        [MAG_BITS-1:0]    w_mag_reg, w_mag_next;
    logic                          w_neg_reg, w_neg_next;
    logic signed [SAMPLE_BITS-1:0] w_before_reg, w_before_next;
    // multiply stage
    logic                          m_valid_reg, m_valid_next;
    logic        [PHI_BITS-1:0]    m_phi_reg, m_phi_next;
    logic        [PLO_BITS-1:0]    m_plo_reg, m_plo_next;
    logic        [WEIGHT_BITS-1:0] m_weight_reg, m_weight_next;
    logic                          m_neg_reg, m_neg_next;
    logic signed [SAMPLE_BITS-1:0] m_before_reg, m_before_next;
    // sum stage
    logic                          s_valid_reg, s_valid_next;
    logic        [MAG_BITS-1:0]    s_scaled_reg, s_scaled_next;
    logic        [WEIGHT_BITS-1:0] s_weight_reg, s_weight_next;
    logic                          s_neg_reg, s_neg_next;
    logic signed [SAMPLE_BITS-1:0] s_before_reg, s_before_next;
    // output register
    logic                          o_valid_reg, o_valid_next;
    logic signed [SAMPLE_BITS-1:0] o_blended_reg, o_blended_next;
    logic        [WEIGHT_BITS-1:0] o_weight_reg, o_weight_next;

    logic                          w_ready, m_ready, s_ready, o_ready;
    logic        [WEIGHT_BITS-1:0] weight;
    logic        [PHI_BITS-1:0]    sum_full;
    logic signed [SUM_BITS-1:0]    delta;
    logic signed [SUM_BITS-1:0]    total;

    assign o_ready  = !o_valid_reg || out_ready;
    assign s_ready  = !s_valid_reg || o_ready;
    assign m_ready  = !m_valid_reg || s_ready;
    assign w_ready  = !w_valid_reg || m_ready;
    assign in_ready = w_ready;

    always_comb
    begin
        case (in_ctrl.kind)
            KIND_ZERO: weight = '0;
            KIND_ONE:  weight = WEIGHT_ONE;
            KIND_DIV:  weight = WEIGHT_BITS'(in_quo);
            default:   weight = '0;
        endcase
        if (invert_mask)
            weight = WEIGHT_ONE - weight;

        w_valid_next  = w_ready ? in_valid : w_valid_reg;
        w_weight_next = w_weight_reg;
        w_mag_next    = w_mag_reg;
        w_neg_next    = w_neg_reg;
        w_before_next = w_before_reg;
        if (in_valid && w_ready)
        begin
            w_weight_next = weight;
            w_mag_next    = in_mag;
            w_neg_next    = in_ctrl.neg;
            w_before_next = in_before;
        end

        // split the magnitude at the weight point to keep each product narrow
        m_valid_next  = m_ready ? w_valid_reg : m_valid_reg;
        m_phi_next    = m_phi_reg;
        m_plo_next    = m_plo_reg;
        m_weight_next = m_weight_reg;
        m_neg_next    = m_neg_reg;
        m_before_next = m_before_reg;
        if (w_valid_reg && m_ready)
        begin
            m_phi_next    = PHI_BITS'(w_mag_reg[MAG_BITS-1:WEIGHT_FRAC])
                          * PHI_BITS'(w_weight_reg);
            m_plo_next    = PLO_BITS'(w_mag_reg[WEIGHT_FRAC-1:0])
                          * PLO_BITS'(w_weight_reg);
            m_weight_next = w_weight_reg;
            m_neg_next    = w_neg_reg;
            m_before_next = w_before_reg;
        end

        sum_full      = m_phi_reg + PHI_BITS'(m_plo_reg >> WEIGHT_FRAC);
        s_valid_next  = s_ready ? m_valid_reg : s_valid_reg;
        s_scaled_next = s_scaled_reg;
        s_weight_next = s_weight_reg;
        s_neg_next    = s_neg_reg;
        s_before_next = s_before_reg;
        if (m_valid_reg && s_ready)
        begin
            // scaled magnitude never exceeds the difference magnitude
            s_scaled_next = sum_full[MAG_BITS-1:0];
            s_weight_next = m_weight_reg;
            s_neg_next    = m_neg_reg;
            s_before_next = m_before_reg;
        end

        delta          = s_neg_reg ? -$signed({1'b0, s_scaled_reg})
                                   : $signed({1'b0, s_scaled_reg});
        total          = {{2{s_before_reg[SAMPLE_BITS-1]}}, s_before_reg} + delta;
        o_valid_next   = o_ready ? s_valid_reg : o_valid_reg;
        o_blended_next = o_blended_reg;
        o_weight_next  = o_weight_reg;
        if (s_valid_reg && o_ready)
        begin
            // result lies between before and after, so it fits the sample width
            o_blended_next = total[SAMPLE_BITS-1:0];
            o_weight_next  = s_weight_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg <= w_valid_next;
            m_valid_reg <= m_valid_next;
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_weight_reg  <= w_weight_next;
        w_mag_reg     <= w_mag_next;
        w_neg_reg     <= w_neg_next;
        w_before_reg  <= w_before_next;
        m_phi_reg     <= m_phi_next;
        m_plo_reg     <= m_plo_next;
        m_weight_reg  <= m_weight_next;
        m_neg_reg     <= m_neg_next;
        m_before_reg  <= m_before_next;
        s_scaled_reg  <= s_scaled_next;
        s_weight_reg  <= s_weight_next;
        s_neg_reg     <= s_neg_next;
        s_before_reg  <= s_before_next;
        o_blended_reg <= o_blended_next;
        o_weight_reg  <= o_weight_next;
    end

    assign out_valid      = o_valid_reg;
    assign blended_sample = o_blended_reg;
    assign mix_weight     = o_weight_reg;

endmodule

// ----- hw/rtl/mask_normalized_blend.sv -----
// Top level of the mask normalized blend.
`timescale 1ns / 1ps

// Scan transfers (op = 0) update the running mask minimum and maximum at the
// accepting edge and give no result; first = 1 restarts both from that sample.
// Blend transfers (op = 1) use the min/max as they stand when accepted and give
// one result: mix_weight = (mask - min) / span in Q1.16, clamped to [0, 1] and
// inverted when invert_mask is set, and blended_sample = before + (after -
// before) * mix_weight, truncated toward zero. The block takes one transfer
// every cycle while in_stall is low. A blend passes PIPE_STAGES (22) register
// stages, the first loaded at its accepting edge and the last being the output
// register that presents its result. They are the weight divider, a chain of
// 16 restoring stages each resolving one quotient bit, plus two front stages
// and four back stages (weight, multiply, sum, output). Every stage holds only
// when its successor is full and stalled, so bubbles close up under output
// stall. Write invert_mask only while no blend transfer is in flight.
module mask_normalized_blend
    import mnb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic                          first,
    input  logic signed [SAMPLE_BITS-1:0] mask_sample,
    input  logic signed [SAMPLE_BITS-1:0] before_sample,
    input  logic signed [SAMPLE_BITS-1:0] after_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] blended_sample,
    output logic        [WEIGHT_BITS-1:0] mix_weight
);

    localparam int DEN_BITS = (SAMPLE_BITS > FRAC_BITS) ? SAMPLE_BITS : FRAC_BITS + 1;

    logic invert_mask_reg, invert_mask_next;
    logic front_ready;

    logic                          div_valid  [0:DIV_STEPS];
    logic                          div_ready  [0:DIV_STEPS];
    logic        [DEN_BITS-1:0]    div_rem    [0:DIV_STEPS];
    logic        [DEN_BITS-1:0]    div_den    [0:DIV_STEPS];
    logic        [WEIGHT_FRAC-1:0] div_quo    [0:DIV_STEPS];
    mnb_ctrl_t                     div_ctrl   [0:DIV_STEPS];
    logic        [SAMPLE_BITS:0]   div_mag    [0:DIV_STEPS];
    logic signed [SAMPLE_BITS-1:0] div_before [0:DIV_STEPS];

    assign invert_mask_next = cfg_wr_en ? cfg_wr_data : invert_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            invert_mask_reg <= 1'b0;
        else
            invert_mask_reg <= invert_mask_next;
    end

    assign in_stall   = !front_ready;
    // the quotient builds up through the divider chain from zero
    assign div_quo[0] = '0;

    mnb_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .DEN_BITS    (DEN_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (front_ready),
        .op            (op),
        .first         (first),
        .mask_sample   (mask_sample),
        .before_sample (before_sample),
        .after_sample  (after_sample),
        .out_valid     (div_valid[0]),
        .out_ready     (div_ready[0]),
        .out_rem       (div_rem[0]),
        .out_den       (div_den[0]),
        .out_ctrl      (div_ctrl[0]),
        .out_mag       (div_mag[0]),
        .out_before    (div_before[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        mnb_div_step #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .DEN_BITS    (DEN_BITS)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (div_valid[i]),
            .in_ready   (div_ready[i]),
            .in_rem     (div_rem[i]),
            .in_den     (div_den[i]),
            .in_quo     (div_quo[i]),
            .in_ctrl    (div_ctrl[i]),
            .in_mag     (div_mag[i]),
            .in_before  (div_before[i]),
            .out_valid  (div_valid[i+1]),
            .out_ready  (div_ready[i+1]),
            .out_rem    (div_rem[i+1]),
            .out_den    (div_den[i+1]),
            .out_quo    (div_quo[i+1]),
            .out_ctrl   (div_ctrl[i+1]),
            .out_mag    (div_mag[i+1]),
            .out_before (div_before[i+1])
        );
    end

    mnb_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .invert_mask    (invert_mask_reg),
        .in_valid       (div_valid[DIV_STEPS]),
        .in_ready       (div_ready[DIV_STEPS]),
        .in_quo         (div_quo[DIV_STEPS]),
        .in_ctrl        (div_ctrl[DIV_STEPS]),
        .in_mag         (div_mag[DIV_STEPS]),
        .in_before      (div_before[DIV_STEPS]),
        .out_valid      (out_valid),
        .out_ready      (!out_stall),
        .blended_sample (blended_sample),
        .mix_weight     (mix_weight)
    );

    // final divider remainder is not needed
    logic unused_rem;
    assign unused_rem = ^div_rem[DIV_STEPS] ^ ^div_den[DIV_STEPS];

endmodule

// ----- hw/rtl/mnb_checker.sv -----
// Port-level checker for the mask normalized blend, bound to the top level.
`timescale 1ns / 1ps
`include "mask_normalized_blend_assert.svh"

module mnb_checker
    import mnb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          op,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] blended_sample,
    input logic        [WEIGHT_BITS-1:0] mix_weight
);

    localparam int PEND_BITS = $clog2(PIPE_STAGES + 1) + 1;

    logic [PEND_BITS-1:0] pending_reg, pending_next;
    logic                 blend_in;
    logic                 result_out;

    assign blend_in   = in_valid && !in_stall && op == OP_BLEND;
    assign result_out = out_valid && !out_stall;

    // count blend transfers still owed a result
    always_comb
    begin
        pending_next = pending_reg;
        if (blend_in && !result_out)
            pending_next = pending_reg + PEND_BITS'(1);
        else if (!blend_in && result_out)
            pending_next = pending_reg - PEND_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `MNB_ASSERT_IMPL(a_weight_range, out_valid, mix_weight <= WEIGHT_ONE, "mix weight above one")
    `MNB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(blended_sample) && $stable(mix_weight), "stalled result changed")
    `MNB_ASSERT_IMPL(a_no_orphan, result_out, pending_reg != '0, "result transfer without a pending blend")
    `MNB_ASSERT_IMPL(a_depth, 1'b1, pending_reg <= PEND_BITS'(PIPE_STAGES), "more blends in flight than stages")

endmodule

bind mask_normalized_blend mnb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mnb_checker (.*);
